@@ hw/rtl/sis_pkg.sv @@
// ----------------------------------------------------------------------------
// sis_pkg
// shared types and constants of the star iris scanline span block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sis_pkg;

  // datapath widths, sized for the full range of the 8-bit state fields
  localparam int DP_W   = 10;  // signed working width of operands and divisors
  localparam int PROD_W = 2 * DP_W;
  localparam int MAG_W  = 17;  // magnitude of any product that can occur
  localparam int DIV_W  = 8;   // magnitude of any divisor that can occur
  localparam int CNT_W  = $clog2(MAG_W + 1);
  localparam int STEP_W = 4;

  // shape steps
  localparam logic [7:0] EDGE_X_STEP = 8'd3;
  localparam logic [7:0] EDGE_Y_STEP = 8'd2;
  localparam logic [7:0] PIVOT_STEP  = 8'd1;

  // microprogram addresses
  localparam logic [STEP_W-1:0] STEP_FETCH    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CLEAR    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_GROW     = 4'd2;
  localparam logic [STEP_W-1:0] STEP_SHRINK   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MIRROR   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SETUP    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MUL      = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DIV_INIT = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DIV      = 4'd8;
  localparam logic [STEP_W-1:0] STEP_FIX      = 4'd9;
  localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd10;

  // operation codes, in dispatch order
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_GROW   = 2'd1,
    OP_SHRINK = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_CLEARED = 2'd0,
    MODE_DRAWN   = 2'd1,
    MODE_FULL    = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_FETCH,
    DP_CLEAR,
    DP_GROW,
    DP_SHRINK,
    DP_MIRROR,
    DP_SETUP,
    DP_MUL,
    DP_DIV_INIT,
    DP_DIV,
    DP_FIX,
    DP_EMIT
  } dp_op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_FETCH,
    C_FIXED,
    C_LOOP,
    C_EMIT
  } cond_e;

  typedef struct packed {
    dp_op_e              op;
    cond_e               cond;
    logic [STEP_W-1:0]   target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    op_e  in_op;
    logic fixed;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

@@ hw/rtl/sis_sequencer.sv @@
// ----------------------------------------------------------------------------
// sis_sequencer
// step counter and control store; one control word per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sis_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sis_pkg::status_t  status_i,
  output sis_pkg::dp_op_e   dp_op_o
);

  logic [sis_pkg::STEP_W-1:0] upc_q, upc_d;
  sis_pkg::ucode_t            uword;

  // control store
  always_comb begin
    case (upc_q)
      sis_pkg::STEP_FETCH:
        uword = '{op: sis_pkg::DP_FETCH, cond: sis_pkg::C_FETCH, target: sis_pkg::STEP_CLEAR};
      sis_pkg::STEP_CLEAR:
        uword = '{op: sis_pkg::DP_CLEAR, cond: sis_pkg::C_JUMP, target: sis_pkg::STEP_EMIT};
      sis_pkg::STEP_GROW:
        uword = '{op: sis_pkg::DP_GROW, cond: sis_pkg::C_JUMP, target: sis_pkg::STEP_EMIT};
      sis_pkg::STEP_SHRINK:
        uword = '{op: sis_pkg::DP_SHRINK, cond: sis_pkg::C_JUMP, target: sis_pkg::STEP_EMIT};
      sis_pkg::STEP_MIRROR:
        uword = '{op: sis_pkg::DP_MIRROR, cond: sis_pkg::C_NEXT, target: sis_pkg::STEP_FETCH};
      sis_pkg::STEP_SETUP:
        uword = '{op: sis_pkg::DP_SETUP, cond: sis_pkg::C_FIXED, target: sis_pkg::STEP_EMIT};
      sis_pkg::STEP_MUL:
        uword = '{op: sis_pkg::DP_MUL, cond: sis_pkg::C_NEXT, target: sis_pkg::STEP_FETCH};
      sis_pkg::STEP_DIV_INIT:
        uword = '{op: sis_pkg::DP_DIV_INIT, cond: sis_pkg::C_NEXT, target: sis_pkg::STEP_FETCH};
      sis_pkg::STEP_DIV:
        uword = '{op: sis_pkg::DP_DIV, cond: sis_pkg::C_LOOP, target: sis_pkg::STEP_DIV};
      sis_pkg::STEP_FIX:
        uword = '{op: sis_pkg::DP_FIX, cond: sis_pkg::C_NEXT, target: sis_pkg::STEP_FETCH};
      sis_pkg::STEP_EMIT:
        uword = '{op: sis_pkg::DP_EMIT, cond: sis_pkg::C_EMIT, target: sis_pkg::STEP_FETCH};
      default:
        uword = '{op: sis_pkg::DP_NOP, cond: sis_pkg::C_JUMP, target: sis_pkg::STEP_FETCH};
    endcase
  end

  // next step
  always_comb begin
    upc_d = upc_q + 4'd1;
    case (uword.cond)
      sis_pkg::C_NEXT: upc_d = upc_q + 4'd1;
      sis_pkg::C_JUMP: upc_d = uword.target;
      sis_pkg::C_FETCH: begin
        if (status_i.in_valid) begin
          upc_d = uword.target + sis_pkg::STEP_W'(status_i.in_op);
        end else begin
          upc_d = upc_q;
        end
      end
      sis_pkg::C_FIXED: upc_d = status_i.fixed ? uword.target : upc_q + 4'd1;
      sis_pkg::C_LOOP:  upc_d = status_i.div_last ? upc_q + 4'd1 : uword.target;
      sis_pkg::C_EMIT:  upc_d = status_i.out_busy ? upc_q : uword.target;
      default:          upc_d = sis_pkg::STEP_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= sis_pkg::STEP_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign dp_op_o = uword.op;

  // an accepted transaction always leaves the fetch step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == sis_pkg::STEP_FETCH && status_i.in_valid) |=> (upc_q != sis_pkg::STEP_FETCH))
    else $error("sequencer stayed in fetch after accepting");

  // the program never runs past its last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q <= sis_pkg::STEP_EMIT)
    else $error("step counter outside the program");

endmodule

@@ hw/rtl/sis_divider.sv @@
// ----------------------------------------------------------------------------
// sis_divider
// serial restoring divider on magnitudes, one quotient bit per cycle while step_i is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sis_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic                       step_i,
  input  logic [sis_pkg::MAG_W-1:0]  dividend_i,
  input  logic [sis_pkg::DIV_W-1:0]  divisor_i,
  output logic [sis_pkg::MAG_W-1:0]  quotient_o,
  output logic                       last_o
);

  logic [sis_pkg::MAG_W-1:0] quo_q, quo_d;
  logic [sis_pkg::DIV_W-1:0] rem_q, rem_d;
  logic [sis_pkg::DIV_W-1:0] dvs_q;
  logic [sis_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [sis_pkg::DIV_W:0]   rem_sh;
  logic [sis_pkg::DIV_W:0]   rem_sub;
  logic                      ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[sis_pkg::MAG_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    ge      = (rem_sh >= {1'b0, dvs_q});
    rem_d   = ge ? rem_sub[sis_pkg::DIV_W-1:0] : rem_sh[sis_pkg::DIV_W-1:0];
    quo_d   = {quo_q[sis_pkg::MAG_W-2:0], ge};
    cnt_d   = cnt_q;
    if (load_i) begin
      cnt_d = sis_pkg::CNT_W'(sis_pkg::MAG_W);
    end else if (step_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (step_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;
  assign last_o     = (cnt_q == sis_pkg::CNT_W'(1));

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (cnt_q == sis_pkg::CNT_W'(sis_pkg::MAG_W)))
    else $error("divider count not loaded");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> (cnt_q != '0))
    else $error("divider stepped with no bits left");

endmodule

@@ hw/rtl/sis_datapath.sv @@
// ----------------------------------------------------------------------------
// sis_datapath
// shape registers, row mirroring, operand setup, multiplier, divider and output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sis_datapath #(
  parameter int unsigned SCREEN_WIDTH    = 240,
  parameter int unsigned SCREEN_HEIGHT   = 160,
  parameter int unsigned SLOW_PHASE_ROWS = 60
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sis_pkg::dp_op_e   op_i,
  output sis_pkg::status_t  status_o,
  input  logic              s_tvalid_i,
  input  logic [1:0]        s_op_i,
  input  logic [7:0]        s_row_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [23:0]       m_tdata_o
);

  localparam int DW = sis_pkg::DP_W;
  localparam int PW = sis_pkg::PROD_W;

  localparam logic signed [DW-1:0] HALF_W_S = DW'(SCREEN_WIDTH / 2);
  localparam logic signed [DW-1:0] HALF_H_S = DW'(SCREEN_HEIGHT / 2);
  localparam logic signed [DW-1:0] SLOW_S   = DW'(SLOW_PHASE_ROWS);
  localparam logic [8:0]           H_9      = 9'(SCREEN_HEIGHT);
  localparam logic [8:0]           HALF_H_9 = 9'(SCREEN_HEIGHT / 2);
  localparam logic [7:0]           W_8      = 8'(SCREEN_WIDTH);
  localparam logic [7:0]           HALF_W_8 = 8'(SCREEN_WIDTH / 2);

  // shape state
  logic [7:0]      edge_x_q, edge_y_q, pivot_y_q;
  sis_pkg::mode_e  mode_q;

  // per transaction working registers
  logic [7:0]             row_q;
  logic [7:0]             m_q;
  logic signed [DW-1:0]   a_q, b_q, den_q;
  logic [7:0]             off_q;
  logic signed [PW-1:0]   prod_q;
  logic                   neg_q, denz_q;
  logic [7:0]             res_left_q, res_right_q;
  logic                   res_done_q;
  logic [23:0]            m_tdata_q;
  logic                   m_tvalid_q;

  logic signed [DW-1:0]   p10, ex10, ey10, m10, half_p, px10;
  logic                   upper, full_span, fixed, out_busy, in_acc;
  logic [8:0]             row9, r9, mir9;
  logic [7:0]             m_d;
  logic signed [DW-1:0]   a_d, b_d, den_d;
  logic [7:0]             off_d;
  logic [PW-1:0]          prod_abs;
  logic [DW-1:0]          den_abs;
  logic [sis_pkg::MAG_W-1:0] quo;
  logic                   div_last;
  logic [7:0]             qs, col;
  logic [7:0]             pivot_dec;

  always_comb begin
    p10    = DW'(signed'(pivot_y_q));
    ex10   = DW'(signed'(edge_x_q));
    ey10   = DW'(signed'(edge_y_q));
    m10    = signed'({2'b00, m_q});
    half_p = (p10 + signed'({{(DW-1){1'b0}}, p10[DW-1]})) >>> 1;
    px10   = p10 + half_p;
    upper  = (m10 < p10);

    full_span = (mode_q == sis_pkg::MODE_FULL) ||
                (mode_q == sis_pkg::MODE_DRAWN && m10 < ey10);
    fixed     = !(mode_q == sis_pkg::MODE_DRAWN && !(m10 < ey10));

    den_d = upper ? (p10 - ey10) : (p10 - HALF_H_S);
    a_d   = upper ? (m10 - ey10) : (px10 - ex10);
    b_d   = upper ? (px10 - HALF_W_S) : (m10 - HALF_H_S);
    off_d = upper ? HALF_W_8 : edge_x_q;

    // fold the row into the top half
    row9 = {1'b0, row_q};
    r9   = (row9 < H_9) ? row9 : 9'd0;
    mir9 = H_9 - 9'd1 - r9;
    m_d  = (r9 >= HALF_H_9 && r9 != mir9) ? mir9[7:0] : r9[7:0];

    prod_abs = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
    den_abs  = den_q[DW-1] ? DW'(-den_q) : DW'(den_q);

    qs  = neg_q ? (~quo[7:0] + 8'd1) : quo[7:0];
    col = off_q + (denz_q ? 8'd0 : qs);

    pivot_dec = pivot_y_q - sis_pkg::PIVOT_STEP;

    out_busy = m_tvalid_q && !m_tready_i;
    in_acc   = (op_i == sis_pkg::DP_FETCH) && s_tvalid_i;
  end

  sis_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (op_i == sis_pkg::DP_DIV_INIT),
    .step_i     (op_i == sis_pkg::DP_DIV),
    .dividend_i (prod_abs[sis_pkg::MAG_W-1:0]),
    .divisor_i  (den_abs[sis_pkg::DIV_W-1:0]),
    .quotient_o (quo),
    .last_o     (div_last)
  );

  // shape state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_x_q   <= '0;
      edge_y_q   <= '0;
      pivot_y_q  <= '0;
      mode_q     <= sis_pkg::MODE_CLEARED;
      m_tvalid_q <= 1'b0;
    end else begin
      case (op_i)
        sis_pkg::DP_CLEAR: begin
          edge_x_q  <= '0;
          edge_y_q  <= '0;
          pivot_y_q <= '0;
          mode_q    <= sis_pkg::MODE_CLEARED;
        end
        sis_pkg::DP_GROW: begin
          if (p10 >= HALF_H_S) begin
            mode_q <= sis_pkg::MODE_FULL;
          end else begin
            if (p10 >= SLOW_S) begin
              edge_x_q <= edge_x_q + sis_pkg::EDGE_X_STEP;
              edge_y_q <= edge_y_q + sis_pkg::EDGE_Y_STEP;
            end
            pivot_y_q <= pivot_y_q + sis_pkg::PIVOT_STEP;
            mode_q    <= sis_pkg::MODE_DRAWN;
          end
        end
        sis_pkg::DP_SHRINK: begin
          if (p10 >= SLOW_S) begin
            edge_x_q <= edge_x_q - sis_pkg::EDGE_X_STEP;
            edge_y_q <= edge_y_q - sis_pkg::EDGE_Y_STEP;
          end
          pivot_y_q <= pivot_dec;
          mode_q    <= sis_pkg::MODE_DRAWN;
        end
        default: begin
        end
      endcase
      if (op_i == sis_pkg::DP_EMIT && !out_busy) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      row_q <= s_row_i;
    end
    case (op_i)
      sis_pkg::DP_CLEAR: begin
        res_left_q  <= '0;
        res_right_q <= '0;
        res_done_q  <= 1'b0;
      end
      sis_pkg::DP_GROW: begin
        res_left_q  <= '0;
        res_right_q <= '0;
        res_done_q  <= (p10 >= HALF_H_S);
      end
      sis_pkg::DP_SHRINK: begin
        res_left_q  <= '0;
        res_right_q <= '0;
        res_done_q  <= pivot_dec[7];
      end
      sis_pkg::DP_MIRROR: m_q <= m_d;
      sis_pkg::DP_SETUP: begin
        a_q         <= a_d;
        b_q         <= b_d;
        den_q       <= den_d;
        off_q       <= off_d;
        res_left_q  <= '0;
        res_right_q <= full_span ? W_8 : 8'd0;
        res_done_q  <= 1'b0;
      end
      sis_pkg::DP_MUL: prod_q <= a_q * b_q;
      sis_pkg::DP_DIV_INIT: begin
        neg_q  <= prod_q[PW-1] ^ den_q[DW-1];
        denz_q <= (den_q == '0);
      end
      sis_pkg::DP_FIX: begin
        res_left_q  <= W_8 - col;
        res_right_q <= col - 8'd1;
      end
      sis_pkg::DP_EMIT: begin
        if (!out_busy) begin
          m_tdata_q <= {7'd0, res_done_q, res_right_q, res_left_q};
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o = '{in_valid: s_tvalid_i, in_op: sis_pkg::op_e'(s_op_i), fixed: fixed,
                      div_last: div_last, out_busy: out_busy};
  assign s_tready_o = (op_i == sis_pkg::DP_FETCH);
  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;

  // a result appears only from the emit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> $past(op_i == sis_pkg::DP_EMIT))
    else $error("result raised outside the emit step");

  // the pivot moves only on shape operations
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i != sis_pkg::DP_GROW && op_i != sis_pkg::DP_SHRINK && op_i != sis_pkg::DP_CLEAR)
    |=> $stable(pivot_y_q))
    else $error("pivot changed outside a frame step");

endmodule

@@ hw/rtl/star_iris_scanline_span_core.sv @@
// ----------------------------------------------------------------------------
// star_iris_scanline_span_core
// star shaped window span per scanline, worked out by a microcoded datapath
// ----------------------------------------------------------------------------
//  channel  | dir | fields (lowest bit first)
//  s_axis   | in  | tuser: operation[1:0]; tdata: row[7:0]
//  m_axis   | out | tdata: span_left[7:0], span_right[15:8], done_res[16], zero[23:17]
//
//  a frame operation runs its shape step, then emit; a query runs mirror and setup,
//  then, unless the span is fixed, multiply, divider load, the serial divider and fix
//  one transaction is in flight at a time; the next is taken while a result waits
//  reset clears the outline, the mode and the step counter at once
//  a stalled output holds the sequencer at its emit step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module star_iris_scanline_span_core #(
  parameter int unsigned SCREEN_WIDTH    = 240,
  parameter int unsigned SCREEN_HEIGHT   = 160,
  parameter int unsigned SLOW_PHASE_ROWS = 60
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // row
  input  logic [1:0]  s_axis_tuser_i,   // operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // span_left, span_right, done_res
);

  sis_pkg::status_t status;
  sis_pkg::dp_op_e  dp_op;

  sis_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .dp_op_o  (dp_op)
  );

  sis_datapath #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .SLOW_PHASE_ROWS (SLOW_PHASE_ROWS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (dp_op),
    .status_o   (status),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_op_i     (s_axis_tuser_i),
    .s_row_i    (s_axis_tdata_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule
